// ===== hdl/assert_macros.svh =====
// assertion helper macros for the led fade engine
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication under synchronous active-low reset
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/mlfe_pkg.sv =====
// shared types and constants of the led fade engine
// no dependencies; imported by every module of the block
`default_nettype none

package mlfe_pkg;

    localparam int PWM_BITS = 12;
    localparam int FADE_W   = 16;
    localparam int LEVEL_W  = 7;
    localparam int CHAN_W   = 10;
    localparam int TIME_W   = 32;
    localparam int PROD_W   = FADE_W + PWM_BITS;

    localparam logic [PWM_BITS-1:0] PWM_MAX    = PWM_BITS'((1 << PWM_BITS) - 1);
    localparam logic [FADE_W-1:0]   FADE_RESET = 16'd1000;
    localparam logic [LEVEL_W-1:0]  LEVEL_FULL = 7'd100;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_SET     = 3'd1,
        MODE_ON      = 3'd2,
        MODE_OFF     = 3'd3,
        MODE_REFRESH = 3'd4
    } mode_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [CHAN_W-1:0] channel;
        logic [LEVEL_W-1:0] brightness;
        logic [FADE_W-1:0] fade_ms;
        logic              use_default_fade;
    } in_beat_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   out_channel;
        logic [PWM_BITS-1:0] pwm_value;
        logic                pwm_changed;
        logic                fade_done;
        logic [LEVEL_W-1:0]  level_percent;
        logic                is_on;
    } out_beat_t;

    typedef struct packed {
        logic [PWM_BITS-1:0] start_level;
        logic [PWM_BITS-1:0] current_level;
        logic [PWM_BITS-1:0] target_level;
        logic [TIME_W-1:0]   fade_start_time;
        logic [FADE_W-1:0]   fade_length;
        logic [LEVEL_W-1:0]  remembered_level;
    } chan_entry_t;

endpackage

`default_nettype wire

// ===== hdl/mlfe_mem.sv =====
// per-channel fade state memory, one read and one write port
// depends on mlfe_pkg for the entry layout
`default_nettype none

module mlfe_mem #(
    parameter int DEPTH = 160,
    parameter int AW    = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output mlfe_pkg::chan_entry_t     rd_data,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire mlfe_pkg::chan_entry_t wr_data
);
    import mlfe_pkg::*;

    chan_entry_t state_mem_reg [DEPTH];
    chan_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            state_mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= state_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/mlfe_mul.sv =====
// bit-serial shift-add multiplier, elapsed time by level difference
// depends on mlfe_pkg for operand widths
`default_nettype none

module mlfe_mul (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [mlfe_pkg::FADE_W-1:0]   op_a,
    input  wire logic [mlfe_pkg::PWM_BITS-1:0] op_b,
    output logic                               busy,
    output logic [mlfe_pkg::PROD_W-1:0]        product
);
    import mlfe_pkg::*;

    localparam int CNT_W = $clog2(PWM_BITS + 1);

    logic [FADE_W-1:0]   a_reg;
    logic [FADE_W-1:0]   hi_reg, hi_next;
    logic [PWM_BITS-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic [FADE_W:0]     sum;

    // one multiplier bit per cycle, partial sum shifts right into lo
    always_comb begin
        sum = lo_reg[0] ? ({1'b0, hi_reg} + {1'b0, a_reg}) : {1'b0, hi_reg};
        hi_next = sum[FADE_W:1];
        lo_next = {sum[0], lo_reg[PWM_BITS-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(PWM_BITS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= op_a;
            hi_reg <= '0;
            lo_reg <= op_b;
        end else if (busy_reg) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign busy    = busy_reg;
    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// ===== hdl/mlfe_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on mlfe_pkg for dividend and divisor widths
`default_nettype none

module mlfe_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [mlfe_pkg::PROD_W-1:0] dividend,
    input  wire logic [mlfe_pkg::FADE_W-1:0] divisor,
    output logic                             busy,
    output logic [mlfe_pkg::PROD_W-1:0]      quotient
);
    import mlfe_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [FADE_W-1:0] div_reg;
    logic [FADE_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [FADE_W:0]   shifted;
    logic              q_bit;

    always_comb begin
        shifted = {rem_reg, quo_reg[PROD_W-1]};
        q_bit   = (shifted >= {1'b0, div_reg});
        rem_next = q_bit ? FADE_W'(shifted - {1'b0, div_reg}) : shifted[FADE_W-1:0];
        quo_next = {quo_reg[PROD_W-2:0], q_bit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(PROD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/multichannel_led_fade_engine.sv =====
// multichannel linear pwm fade engine, top level; uses mlfe_pkg, mlfe_mem, mlfe_mul, mlfe_div
// path of each accepted beat: tick or ignored beat stays in idle, idle-channel refresh read,
// completed-fade refresh read, finish, out; command read, 28-step serial divide, finish;
// mid-fade refresh read, 12-step serial multiply, 28-step serial divide, finish, out;
// one beat in flight, a result waiting on m_ready holds s_ready low
// reset: synchronous active low, then a clearing pass over all CHANNELS entries with s_ready low
`default_nettype none

module multichannel_led_fade_engine #(
    parameter int CHANNELS = 160
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration: default fade length
    input  wire logic                        cfg_wr_en,
    input  wire logic [mlfe_pkg::FADE_W-1:0] cfg_wr_data,
    // command / tick / refresh beats
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire mlfe_pkg::in_beat_t          s_data,
    // result beats
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output mlfe_pkg::out_beat_t              m_data
);
    import mlfe_pkg::*;

    `include "assert_macros.svh"

    localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PX_W = PWM_BITS + LEVEL_W;
    localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);

    // one-hot sequencer states
    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_FINISH = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    // pwm * 100 / PWM_MAX truncated; 100 = 64 + 32 + 4, and division by
    // 2^n - 1 is a shift plus one correction since the quotient stays small
    function automatic logic [LEVEL_W-1:0] pwm_to_percent(input logic [PWM_BITS-1:0] v);
        logic [PX_W-1:0]     x;
        logic [LEVEL_W-1:0]  q0;
        logic [PWM_BITS:0]   r;
        x  = PX_W'({v, 6'b0}) + PX_W'({v, 5'b0}) + PX_W'({v, 2'b0});
        q0 = x[PX_W-1:PWM_BITS];
        r  = {1'b0, x[PWM_BITS-1:0]} + (PWM_BITS + 1)'(q0);
        if (r >= {1'b0, PWM_MAX}) begin
            q0 = q0 + 1'b1;
        end
        return q0;
    endfunction

    state_t state_reg, state_next;

    logic [TIME_W-1:0]  now_ms_reg, now_ms_next;
    logic [FADE_W-1:0]  dflt_fade_reg;
    logic [2:0]         mode_reg, mode_next;
    logic [CHAN_W-1:0]  ch_reg, ch_next;
    logic [LEVEL_W-1:0] bright_reg, bright_next;
    logic [FADE_W-1:0]  dur_reg, dur_next;
    logic               snap_reg, snap_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    out_beat_t          res_reg, res_next;
    out_beat_t          m_data_reg, m_data_next;
    logic               m_valid_reg, m_valid_next;

    // memory port
    logic               rd_en;
    chan_entry_t        ent;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    chan_entry_t        wr_data;

    // serial units
    logic               mul_start, mul_busy;
    logic [PROD_W-1:0]  mul_prod;
    logic               div_start, div_busy;
    logic [PROD_W-1:0]  div_dividend, div_quo;
    logic [FADE_W-1:0]  div_divisor;

    // datapath terms, from the incoming beat and the entry read for the current beat
    logic               s_accept;
    logic               ch_in_range;
    logic               is_cmd;
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  elapsed;
    logic               snap;
    logic               going_up;
    logic [PWM_BITS-1:0] diff;
    logic [PWM_BITS-1:0] q_lvl;
    logic [PWM_BITS-1:0] nv;
    logic               changed;
    logic               done;
    logic [PROD_W-1:0]  cmd_dividend;
    logic [PROD_W-1:0]  ref_dividend;
    chan_entry_t        clear_entry;

    assign s_accept    = s_valid && s_ready;
    assign ch_in_range = ({1'b0, s_data.channel} < (CHAN_W + 1)'(CHANNELS));
    assign is_cmd      = (mode_reg != MODE_REFRESH);

    always_comb begin
        unique case (mode_reg)
            MODE_SET: level = (bright_reg > LEVEL_FULL) ? LEVEL_FULL : bright_reg;
            MODE_ON:  level = ent.remembered_level;
            default:  level = '0;
        endcase
    end

    // elapsed count wraps modulo 2^32 with the millisecond counter
    assign elapsed  = now_ms_reg - ent.fade_start_time;
    assign snap     = (elapsed >= TIME_W'(ent.fade_length));
    assign going_up = (ent.target_level >= ent.start_level);
    assign diff     = going_up ? (ent.target_level - ent.start_level)
                               : (ent.start_level - ent.target_level);
    assign q_lvl    = div_quo[PWM_BITS-1:0];

    // target = level * PWM_MAX / 100, level * PWM_MAX as shift minus level
    assign cmd_dividend = PROD_W'({level, {PWM_BITS{1'b0}}}) - PROD_W'(level);
    // downward fades round the step up, which floors the new value
    assign ref_dividend = going_up ? mul_prod
                                   : PROD_W'({1'b0, mul_prod} + (PROD_W + 1)'(ent.fade_length)
                                             - (PROD_W + 1)'(1));
    assign div_dividend = is_cmd ? cmd_dividend : ref_dividend;
    assign div_divisor  = is_cmd ? FADE_W'(LEVEL_FULL) : ent.fade_length;

    assign nv      = snap_reg ? ent.target_level
                              : (going_up ? (ent.start_level + q_lvl)
                                          : (ent.start_level - q_lvl));
    assign changed = (nv != ent.current_level);
    assign done    = (nv == ent.target_level);

    always_comb begin
        clear_entry                  = '0;
        clear_entry.fade_length      = FADE_RESET;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        now_ms_next  = now_ms_reg;
        mode_next    = mode_reg;
        ch_next      = ch_reg;
        bright_next  = bright_reg;
        dur_next     = dur_reg;
        snap_next    = snap_reg;
        clr_cnt_next = clr_cnt_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = ch_reg[AW-1:0];
        wr_data      = ent;
        mul_start    = 1'b0;
        div_start    = 1'b0;

        // result beat leaves the output register
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = clear_entry;
                if (clr_cnt_reg == LAST_CH) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    rd_en       = 1'b1;
                    mode_next   = s_data.mode;
                    ch_next     = s_data.channel;
                    bright_next = s_data.brightness;
                    dur_next    = s_data.use_default_fade ? dflt_fade_reg : s_data.fade_ms;
                    unique case (s_data.mode) inside
                        MODE_TICK: begin
                            now_ms_next = now_ms_reg + 1'b1;
                        end
                        MODE_SET, MODE_ON, MODE_OFF, MODE_REFRESH: begin
                            if (ch_in_range) begin
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                            // unused modes are dropped
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (is_cmd) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else if (ent.current_level == ent.target_level) begin
                    // channel at rest, nothing to report
                    state_next = ST_IDLE;
                end else if (snap) begin
                    snap_next  = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    snap_next  = 1'b0;
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (!mul_busy) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (is_cmd) begin
                    // new fade from the present value, stamped now
                    wr_en                    = 1'b1;
                    wr_data.start_level      = ent.current_level;
                    wr_data.target_level     = q_lvl;
                    wr_data.fade_start_time  = now_ms_reg;
                    wr_data.fade_length      = dur_reg;
                    if (level != '0) begin
                        wr_data.remembered_level = level;
                    end
                    state_next = ST_IDLE;
                end else begin
                    wr_en                 = changed;
                    wr_data.current_level = nv;
                    res_next.out_channel   = ch_reg;
                    res_next.pwm_value     = nv;
                    res_next.pwm_changed   = changed;
                    res_next.fade_done     = done;
                    res_next.level_percent = done ? pwm_to_percent(nv) : '0;
                    res_next.is_on         = (nv != '0);
                    state_next = (changed || done) ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            now_ms_reg    <= '0;
            dflt_fade_reg <= FADE_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            now_ms_reg  <= now_ms_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                dflt_fade_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        ch_reg     <= ch_next;
        bright_reg <= bright_next;
        dur_reg    <= dur_next;
        snap_reg   <= snap_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    mlfe_mem #(
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (s_data.channel[AW-1:0]),
        .rd_data (ent),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    mlfe_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (elapsed[FADE_W-1:0]),
        .op_b    (diff),
        .busy    (mul_busy),
        .product (mul_prod)
    );

    mlfe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // memory writes come only from the clearing pass or the finish step
    `ASSERT_IMPLIES(a_wr_src, aclk, aresetn, wr_en, (state_reg == ST_CLEAR) || (state_reg == ST_FINISH))
    // a loaded result beat always carries a change or a completion
    `ASSERT_NEXT(a_res_meaning, aclk, aresetn, (state_reg == ST_OUT) && (!m_valid_reg || m_ready), m_valid && (m_data.pwm_changed || m_data.fade_done))
    // an accepted tick advances the millisecond count by one
    `ASSERT_NEXT(a_tick, aclk, aresetn, s_accept && (s_data.mode == MODE_TICK), now_ms_reg == $past(now_ms_reg) + 1'b1)
    // reported level never exceeds full scale
    `ASSERT_IMPLIES(a_pct_range, aclk, aresetn, m_valid, m_data.level_percent <= LEVEL_FULL)

endmodule

`default_nettype wire

// ===== tb/multichannel_led_fade_engine_tb.sv =====
// self-checking testbench for the multichannel led fade engine
// depends on mlfe_pkg and multichannel_led_fade_engine; the scoreboard class predicts results
`default_nettype none

module multichannel_led_fade_engine_tb;
    import mlfe_pkg::*;

    localparam int N_CHAN        = 160;
    localparam int RANDOM_ITEMS  = 450;
    localparam int N_PHASES      = 5;
    localparam int SETTLE_CYCLES = 64;      // longer than a mid-fade refresh
    localparam int LONG_HOLD     = 400;
    localparam int RUN_LIMIT     = 2000000; // time units

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [FADE_W-1:0]   cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    in_beat_t            s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    out_beat_t           m_data;

    // sender-side controls
    logic                hold_req    = 1'b0; // asks the receiver for one long hold-off
    bit                  tx_quiet;           // when set, the sender runs back to back
    int                  counted_beats;      // beats that the block acts on

    // per-channel fade state and the queue of results still owed by the block
    class fade_scoreboard;
        logic [PWM_BITS-1:0] start_lvl [N_CHAN];
        logic [PWM_BITS-1:0] cur_lvl   [N_CHAN];
        logic [PWM_BITS-1:0] tgt_lvl   [N_CHAN];
        logic [TIME_W-1:0]   fade_t0   [N_CHAN];
        logic [FADE_W-1:0]   fade_len  [N_CHAN];
        logic [LEVEL_W-1:0]  saved_pct [N_CHAN];
        logic [TIME_W-1:0]   now_ms;
        logic [FADE_W-1:0]   default_fade;
        out_beat_t           expected_q[$];
        int                  error_count;
        int                  result_count;

        function new();
            for (int i = 0; i < N_CHAN; i++) begin
                start_lvl[i] = '0;
                cur_lvl[i]   = '0;
                tgt_lvl[i]   = '0;
                fade_t0[i]   = '0;
                fade_len[i]  = FADE_RESET;
                saved_pct[i] = '0;
            end
            now_ms       = '0;
            default_fade = FADE_RESET;
            error_count  = 0;
            result_count = 0;
        endfunction

        function void start_fade(int unsigned ch, int unsigned pct, logic [FADE_W-1:0] dur);
            int unsigned lvl;
            int unsigned tgt;
            lvl = (pct > LEVEL_FULL) ? LEVEL_FULL : pct;
            tgt = lvl * PWM_MAX / LEVEL_FULL;
            start_lvl[ch] = cur_lvl[ch];
            tgt_lvl[ch]   = PWM_BITS'(tgt);
            fade_t0[ch]   = now_ms;
            fade_len[ch]  = dur;
            if (lvl > 0)
                saved_pct[ch] = LEVEL_W'(lvl);
        endfunction

        function void refresh_channel(int unsigned ch);
            logic [TIME_W-1:0] elapsed;
            longint unsigned   span;
            int unsigned       st, tgt, cur, len, nv;
            out_beat_t         res;
            cur = cur_lvl[ch];
            tgt = tgt_lvl[ch];
            if (cur == tgt)
                return;
            st      = start_lvl[ch];
            len     = fade_len[ch];
            elapsed = now_ms - fade_t0[ch];
            span    = elapsed;
            if (elapsed >= len) begin
                nv = tgt;
            end else if (tgt >= st) begin
                span = span * (tgt - st);
                nv   = st + int'(span / len);
            end else begin
                // falling fades round the step up
                span = span * (st - tgt);
                nv   = st - int'((span + len - 1) / len);
            end
            res.out_channel   = CHAN_W'(ch);
            res.pwm_value     = PWM_BITS'(nv);
            res.pwm_changed   = (nv != cur);
            res.fade_done     = (nv == tgt);
            res.level_percent = res.fade_done ? LEVEL_W'(nv * LEVEL_FULL / PWM_MAX) : '0;
            res.is_on         = (nv != 0);
            if (res.pwm_changed)
                cur_lvl[ch] = PWM_BITS'(nv);
            if (!res.pwm_changed && !res.fade_done)
                return;
            expected_q.push_back(res);
        endfunction

        function void note_beat(in_beat_t b);
            int unsigned       ch;
            logic [FADE_W-1:0] dur;
            ch  = b.channel;
            dur = b.use_default_fade ? default_fade : b.fade_ms;
            if (b.mode == MODE_TICK) begin
                now_ms = now_ms + 1'b1;
                return;
            end
            if (b.mode > MODE_REFRESH || ch >= N_CHAN)
                return;
            case (b.mode)
                MODE_SET: start_fade(ch, b.brightness, dur);
                MODE_ON:  start_fade(ch, saved_pct[ch], dur);
                MODE_OFF: start_fade(ch, 0, dur);
                default:  refresh_channel(ch);
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing pending: channel %0d value %0d",
                       got.out_channel, got.pwm_value);
                error_count++;
                return;
            end
            want = expected_q.pop_front();
            result_count++;
            check_field("out_channel",   want.out_channel,   got.out_channel);
            check_field("pwm_value",     want.pwm_value,     got.pwm_value);
            check_field("pwm_changed",   want.pwm_changed,   got.pwm_changed);
            check_field("fade_done",     want.fade_done,     got.fade_done);
            check_field("level_percent", want.level_percent, got.level_percent);
            check_field("is_on",         want.is_on,         got.is_on);
        endfunction
    endclass

    fade_scoreboard board = new();

    multichannel_led_fade_engine #(
        .CHANNELS(N_CHAN)
    ) u_top (
        .aclk,
        .aresetn,
        .cfg_wr_en,
        .cfg_wr_data,
        .s_valid,
        .s_ready,
        .s_data,
        .m_valid,
        .m_ready,
        .m_data
    );

    always #1 aclk = ~aclk;

    // both monitors sample at the edge, before any driver update lands
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.note_beat(s_data);
        if (aresetn && m_valid && m_ready)
            board.check_result(m_data);
    end

    // idle length shared by sender and receiver: mostly short, a few long
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    // builds one beat, waits out a gap, then holds valid until the block takes it
    task automatic issue(input logic [2:0] mode, input int unsigned ch, input int unsigned pct,
                         input int unsigned fade, input bit use_def);
        in_beat_t b;
        int       gap;
        b.mode             = mode;
        b.channel          = CHAN_W'(ch);
        b.brightness       = LEVEL_W'(pct);
        b.fade_ms          = FADE_W'(fade);
        b.use_default_fade = use_def;
        gap = tx_quiet ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        if (b.mode == MODE_TICK || (b.mode <= MODE_REFRESH && b.channel < N_CHAN))
            counted_beats++;
    endtask

    // sender pause: nothing owed any more, then room for a beat that causes no result
    task automatic settle();
        s_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_default_fade(input logic [FADE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.default_fade = value;
    endtask

    // a few hot channels keep overlapping fades alive across sequences
    function automatic int unsigned pick_channel();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, N_CHAN - 1);
            1:       return N_CHAN - 1;
            default: return $urandom_range(0, 2);
        endcase
    endfunction

    // mostly short fades so that refreshes see motion; now and then zero or any length
    function automatic int unsigned pick_fade();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(0, 65535);
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    task automatic tick_beat();
        issue(MODE_TICK, $urandom_range(0, 1023), $urandom_range(0, 127), $urandom(),
              1'($urandom_range(0, 1)));
    endtask

    task automatic refresh_beat(input int unsigned ch);
        issue(MODE_REFRESH, ch, $urandom_range(0, 127), $urandom(),
              1'($urandom_range(0, 1)));
    endtask

    // beats the block must drop: unused modes, or channels past the last one
    task automatic noise_beat();
        if ($urandom_range(0, 1) == 0)
            issue(3'($urandom_range(5, 7)), $urandom_range(0, 1023), $urandom_range(0, 127),
                  $urandom(), 1'($urandom_range(0, 1)));
        else
            issue(3'($urandom_range(MODE_SET, MODE_REFRESH)), $urandom_range(N_CHAN, 1023),
                  $urandom_range(0, 127), $urandom(), 1'($urandom_range(0, 1)));
    endtask

    // one command on a channel, then rounds of ticks and refreshes that follow the fade
    task automatic fade_sequence();
        int unsigned ch;
        int unsigned r;
        logic [2:0]  cmd;
        ch = pick_channel();
        r  = $urandom_range(0, 5);
        cmd = (r < 3) ? MODE_SET : (r == 3) ? MODE_ON : MODE_OFF;
        issue(cmd, ch, $urandom_range(0, 127), pick_fade(), $urandom_range(0, 3) == 0);
        repeat ($urandom_range(2, 10)) begin
            repeat ($urandom_range(0, 4)) tick_beat();
            r = $urandom_range(0, 19);
            if (r == 0)
                noise_beat();
            else if (r == 1)
                refresh_beat(pick_channel());
            refresh_beat(ch);
        end
    endtask

    // receiver: ready runs and stalls of random length, plus the long hold-off on request
    initial begin
        int unsigned run_len;
        int          stall_len;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req <= 1'b0;
                m_ready  <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            m_ready <= 1'b1;
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
            repeat (run_len) @(posedge aclk);
            stall_len = idle_len();
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    // sender: reset, directed beats, then random phases under different default fades
    initial begin
        logic [FADE_W-1:0] setting;
        int                phase_end;
        tx_quiet      = 1'b0;
        counted_beats = 0;
        aresetn <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle channel at reset, nothing owed
        refresh_beat(0);
        // reset default fade of 1000 ms gives a small first step
        issue(MODE_SET, 3, 100, 0, 1'b1);
        tick_beat();
        refresh_beat(3);
        // level above 100 saturates, zero duration completes at once
        issue(MODE_SET, 0, 127, 0, 1'b0);
        refresh_beat(0);
        // falling fade: halfway point, then completion at zero
        issue(MODE_OFF, 0, 0, 4, 1'b0);
        tick_beat();
        tick_beat();
        refresh_beat(0);
        tick_beat();
        tick_beat();
        refresh_beat(0);
        // on returns to the remembered full level, off left it untouched
        issue(MODE_ON, 0, 0, 0, 1'b0);
        refresh_beat(0);
        // lowest nonzero level on the last channel
        issue(MODE_SET, N_CHAN - 1, 1, 0, 1'b0);
        refresh_beat(N_CHAN - 1);
        // channels past the end and unused modes are dropped
        issue(MODE_SET, N_CHAN, 50, 0, 1'b0);
        refresh_beat(1023);
        issue(3'd5, 0, 127, 16'hffff, 1'b1);
        issue(3'd7, 1023, 0, 0, 1'b0);
        // on with nothing remembered stays dark, so the refresh owes nothing
        issue(MODE_ON, 5, 0, 3, 1'b0);
        refresh_beat(5);
        // longest fade: one millisecond moves nothing yet
        issue(MODE_SET, 2, 100, 16'hffff, 1'b0);
        tick_beat();
        refresh_beat(2);

        counted_beats = 0;
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            case (p)
                0:       setting = '0;
                1:       setting = '1;
                2:       setting = 16'd6;
                3:       setting = 16'd1;
                default: setting = FADE_W'($urandom_range(2, 40));
            endcase
            write_default_fade(setting);
            tx_quiet = (p == 2);
            // long receiver hold-off while the sender keeps offering beats
            if (p == 1 || p == 3)
                hold_req <= 1'b1;
            phase_end = counted_beats + RANDOM_ITEMS / N_PHASES;
            while (counted_beats < phase_end)
                fade_sequence();
        end

        // drain everything still owed before the verdict
        settle();

        if (board.error_count == 0 && board.expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hard stop in case the block hangs
    initial begin
        #RUN_LIMIT;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
